/* design/pdir_pkg.sv */
`timescale 1ns / 1ps

package pdir_pkg;

   // Register map, one 64-bit register every eight bytes
   typedef enum logic [2:0] {
      REG_CORNER   = 3'd0,
      REG_VERTICAL = 3'd1,
      REG_HORIZ    = 3'd2,
      REG_EYE      = 3'd3,
      REG_WIDTH    = 3'd4,
      REG_HEIGHT   = 3'd5
   } reg_index_type;

   localparam int CSR_DATA_BITS = 64;
   localparam int CSR_ADDR_BITS = 6;
   localparam int DIM_BITS      = 13;
   localparam int PIX_BITS      = 12;
   localparam int DIR_BITS      = 16;

   // Screen size reset values
   localparam logic [DIM_BITS-1:0] WIDTH_RESET  = 13'd640;
   localparam logic [DIM_BITS-1:0] HEIGHT_RESET = 13'd480;

   // The largest normalised magnitude sits in [2^30, 2^31)
   localparam int NORM_MSB  = 30;
   localparam int MAG_BITS  = 31;
   localparam int SUM_BITS  = 64;
   localparam int ROOT_BITS = 32;
   localparam int REM_BITS  = ROOT_BITS + 2;
   localparam int FRAC_BITS = 14;
   localparam int Q_BITS    = 15;
   localparam int NUM_BITS  = MAG_BITS + FRAC_BITS + 1;
   localparam logic [Q_BITS-1:0] ONE_Q14 = 15'd16384;

   // Pipeline stage numbering
   localparam int ST_MUL  = 0;
   localparam int ST_PROD = 1;
   localparam int ST_SUM  = 2;
   localparam int ST_MAG  = 3;
   localparam int ST_GRP  = 4;
   localparam int ST_POS  = 5;
   localparam int ST_SHF  = 6;
   localparam int ST_SQR  = 7;
   localparam int ST_ACC  = 8;
   localparam int ST_RT0  = 9;
   localparam int ST_NUM  = ST_RT0 + ROOT_BITS;
   localparam int ST_DV0  = ST_NUM + 1;
   localparam int ST_OUT  = ST_DV0 + Q_BITS;
   localparam int NUM_STAGES = ST_OUT + 1;

   // Square root stage contents
   typedef struct packed {
      logic [SUM_BITS-1:0]            src;
      logic [REM_BITS-1:0]            rem;
      logic [ROOT_BITS-1:0]           root;
      logic [2:0][MAG_BITS-1:0]       mag;
      logic [2:0]                     neg;
      logic                           degen;
   } sqrt_stage_type;

   // Divider stage contents
   typedef struct packed {
      logic [2:0][NUM_BITS-1:0]       rem;
      logic [2:0][Q_BITS-1:0]         quo;
      logic [ROOT_BITS-1:0]           len;
      logic [2:0]                     neg;
      logic                           degen;
   } div_stage_type;

endpackage

/* design/primary_ray_direction.sv */
`timescale 1ns / 1ps

// Channel   Dir   Handshake             Payload
// req       in    tvalid/tready         tdata: pixel_row, pixel_col
// rsp       out   tvalid/tready         tdata: dir_x, dir_y, dir_z; tuser: degenerate
// csr       in    psel/penable/pwrite   APB registers at 8*i, 64-bit data
//
// One word enters per cycle while rsp does not stall, through 58 register stages;
// these include the 32-step square root and the 15-step divider,
// one result bit per stage.
// Synchronous active-high reset clears all valid bits; configuration registers take reset values.
// A stall on rsp holds the last stage; earlier stages keep filling bubbles.
// No clearing pass after reset.

module primary_ray_direction #(
   parameter int COORD_BITS = 12,
   parameter int COMP_BITS  = 20
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [23:0]                            req_tdata,   // pixel_row, pixel_col
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [47:0]                            rsp_tdata,   // dir_x, dir_y, dir_z
   output logic                                   rsp_tuser,   // degenerate
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [pdir_pkg::CSR_ADDR_BITS-1:0]     csr_paddr,
   input  logic [pdir_pkg::CSR_DATA_BITS-1:0]     csr_pwdata,
   output logic [pdir_pkg::CSR_DATA_BITS-1:0]     csr_prdata,
   output logic                                   csr_pready
);

   localparam int CW   = COMP_BITS;
   localparam int VB   = 3 * CW;
   localparam int DW   = CW + 1;
   localparam int RB   = (COORD_BITS < pdir_pkg::PIX_BITS) ? COORD_BITS : pdir_pkg::PIX_BITS;
   localparam int HWB  = 2 * pdir_pkg::DIM_BITS;
   localparam int RWB  = RB + pdir_pkg::DIM_BITS;
   localparam int P0B  = DW + HWB + 1;
   localparam int P1B  = RWB + 1 + CW;
   localparam int NB   = ((P0B > P1B) ? P0B : P1B) + 2;
   localparam int NG   = (NB + 7) / 8;
   localparam int GB   = NG * 8;
   localparam int PB   = $clog2(GB);
   localparam int NS   = pdir_pkg::NUM_STAGES;

   // ------------------------------------------------------------------
   // Configuration registers
   logic [VB-1:0]                  corner_ff, vert_ff, horiz_ff, eye_ff;
   logic [pdir_pkg::DIM_BITS-1:0]  width_ff, height_ff;
   logic                           csr_wr;
   pdir_pkg::reg_index_type        csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = pdir_pkg::reg_index_type'(csr_paddr[5:3]);

   // Take register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         corner_ff <= '0;
         vert_ff   <= '0;
         horiz_ff  <= '0;
         eye_ff    <= '0;
         width_ff  <= pdir_pkg::WIDTH_RESET;
         height_ff <= pdir_pkg::HEIGHT_RESET;
      end else if (csr_wr) begin
         unique case (csr_idx)
            pdir_pkg::REG_CORNER:   corner_ff <= csr_pwdata[VB-1:0];
            pdir_pkg::REG_VERTICAL: vert_ff   <= csr_pwdata[VB-1:0];
            pdir_pkg::REG_HORIZ:    horiz_ff  <= csr_pwdata[VB-1:0];
            pdir_pkg::REG_EYE:      eye_ff    <= csr_pwdata[VB-1:0];
            pdir_pkg::REG_WIDTH:    width_ff  <= csr_pwdata[pdir_pkg::DIM_BITS-1:0];
            pdir_pkg::REG_HEIGHT:   height_ff <= csr_pwdata[pdir_pkg::DIM_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Read back
   always_comb begin
      csr_prdata = '0;
      unique case (csr_idx)
         pdir_pkg::REG_CORNER:   csr_prdata[VB-1:0] = corner_ff;
         pdir_pkg::REG_VERTICAL: csr_prdata[VB-1:0] = vert_ff;
         pdir_pkg::REG_HORIZ:    csr_prdata[VB-1:0] = horiz_ff;
         pdir_pkg::REG_EYE:      csr_prdata[VB-1:0] = eye_ff;
         pdir_pkg::REG_WIDTH:    csr_prdata[pdir_pkg::DIM_BITS-1:0] = width_ff;
         pdir_pkg::REG_HEIGHT:   csr_prdata[pdir_pkg::DIM_BITS-1:0] = height_ff;
         default: ;
      endcase
   end

   // ------------------------------------------------------------------
   // Stage enables: a stage loads when the next one loads or when it is itself empty
   logic [NS-1:0] v_ff;
   logic [NS-1:0] en;

   always_comb begin
      en[NS-1] = rsp_tready || !v_ff[NS-1];
      for (int k = NS - 2; k >= 0; k--) begin
         en[k] = en[k+1] || !v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < NS; k++) begin
            if (en[k]) begin
               v_ff[k] <= (k == 0) ? req_tvalid : v_ff[(k == 0) ? 0 : k - 1];
            end
         end
      end
   end

   assign req_tready = en[0];
   assign rsp_tvalid = v_ff[NS-1];

   // ------------------------------------------------------------------
   // Stage MUL: row*w, col*h, h*w and corner - eye
   logic [pdir_pkg::DIM_BITS-1:0] w_use, h_use;
   logic [RB-1:0]                 row_use, col_use;
   logic [RWB-1:0]                rw_ff, rw_in, ch_ff, ch_in;
   logic [HWB-1:0]                hw_ff, hw_in;
   logic signed [DW-1:0]          d_ff [3];
   logic signed [DW-1:0]          d_in [3];

   always_comb begin
      w_use   = (width_ff  == '0) ? pdir_pkg::DIM_BITS'(1) : width_ff;
      h_use   = (height_ff == '0) ? pdir_pkg::DIM_BITS'(1) : height_ff;
      row_use = req_tdata[RB-1:0];
      col_use = req_tdata[pdir_pkg::PIX_BITS +: RB];
      rw_in   = RWB'(row_use) * RWB'(w_use);
      ch_in   = RWB'(col_use) * RWB'(h_use);
      hw_in   = HWB'(w_use) * HWB'(h_use);
      for (int i = 0; i < 3; i++) begin
         d_in[i] = $signed({corner_ff[i*CW+CW-1], corner_ff[i*CW +: CW]})
                 - $signed({eye_ff[i*CW+CW-1], eye_ff[i*CW +: CW]});
      end
   end

   always_ff @(posedge clock) begin
      if (en[pdir_pkg::ST_MUL]) begin
         rw_ff <= rw_in;
         ch_ff <= ch_in;
         hw_ff <= hw_in;
         d_ff  <= d_in;
      end
   end

   // Stage PROD: the nine products
   logic signed [P0B-1:0] p0_ff [3];
   logic signed [P0B-1:0] p0_in [3];
   logic signed [P1B-1:0] p1_ff [3];
   logic signed [P1B-1:0] p1_in [3];
   logic signed [P1B-1:0] p2_ff [3];
   logic signed [P1B-1:0] p2_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p0_in[i] = d_ff[i] * $signed({1'b0, hw_ff});
         p1_in[i] = $signed({1'b0, rw_ff}) * $signed(vert_ff[i*CW +: CW]);
         p2_in[i] = $signed({1'b0, ch_ff}) * $signed(horiz_ff[i*CW +: CW]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[pdir_pkg::ST_PROD]) begin
         p0_ff <= p0_in;
         p1_ff <= p1_in;
         p2_ff <= p2_in;
      end
   end

   // Stage SUM: the unnormalised direction
   logic signed [NB-1:0] n_ff [3];
   logic signed [NB-1:0] n_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n_in[i] = NB'(p0_ff[i]) + NB'(p1_ff[i]) + NB'(p2_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[pdir_pkg::ST_SUM]) begin
         n_ff <= n_in;
      end
   end

   // Stage MAG: split into sign and magnitude
   logic [2:0][NB-1:0] mag_ff, mag_in;
   logic [2:0]         neg_ff, neg_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         neg_in[i] = n_ff[i][NB-1];
         mag_in[i] = neg_in[i] ? NB'(-n_ff[i]) : NB'(n_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[pdir_pkg::ST_MAG]) begin
         mag_ff <= mag_in;
         neg_ff <= neg_in;
      end
   end

   // Stage GRP: leading one per byte of the OR of magnitudes
   logic [GB-1:0]      any_bits;
   logic [NG-1:0]      gnz_ff, gnz_in;
   logic [NG-1:0][2:0] glp_ff, glp_in;
   logic [2:0][NB-1:0] mag_g_ff;
   logic [2:0]         neg_g_ff;

   always_comb begin
      any_bits = GB'(mag_ff[0] | mag_ff[1] | mag_ff[2]);
      for (int g = 0; g < NG; g++) begin
         gnz_in[g] = |any_bits[g*8 +: 8];
         glp_in[g] = 3'd0;
         for (int b = 0; b < 8; b++) begin
            if (any_bits[g*8+b]) begin
               glp_in[g] = 3'(b);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[pdir_pkg::ST_GRP]) begin
         gnz_ff   <= gnz_in;
         glp_ff   <= glp_in;
         mag_g_ff <= mag_ff;
         neg_g_ff <= neg_ff;
      end
   end

   // Stage POS: position of the leading one, zero vector check
   logic [PB-1:0]      pos_ff, pos_in;
   logic               zero_ff, zero_in;
   logic [2:0][NB-1:0] mag_p_ff;
   logic [2:0]         neg_p_ff;

   always_comb begin
      pos_in  = '0;
      zero_in = ~|gnz_ff;
      for (int g = 0; g < NG; g++) begin
         if (gnz_ff[g]) begin
            pos_in = PB'(g * 8) + PB'(glp_ff[g]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[pdir_pkg::ST_POS]) begin
         pos_ff   <= pos_in;
         zero_ff  <= zero_in;
         mag_p_ff <= mag_g_ff;
         neg_p_ff <= neg_g_ff;
      end
   end

   // Stage SHF: bring the largest magnitude to [2^30, 2^31)
   logic [NB+pdir_pkg::MAG_BITS-1:0]     ext;
   logic [2:0][pdir_pkg::MAG_BITS-1:0]   nm_ff, nm_in;
   logic [2:0]                           neg_s_ff;
   logic                                 zero_s_ff;

   always_comb begin
      ext = '0;
      for (int i = 0; i < 3; i++) begin
         ext = (NB + pdir_pkg::MAG_BITS)'(mag_p_ff[i]);
         if (pos_ff >= PB'(pdir_pkg::NORM_MSB)) begin
            ext = ext >> (pos_ff - PB'(pdir_pkg::NORM_MSB));
         end else begin
            ext = ext << (PB'(pdir_pkg::NORM_MSB) - pos_ff);
         end
         nm_in[i] = ext[pdir_pkg::MAG_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[pdir_pkg::ST_SHF]) begin
         nm_ff     <= nm_in;
         neg_s_ff  <= neg_p_ff;
         zero_s_ff <= zero_ff;
      end
   end

   // Stage SQR: squares
   logic [2:0][2*pdir_pkg::MAG_BITS-1:0] sq_ff, sq_in;
   logic [2:0][pdir_pkg::MAG_BITS-1:0]   nm_q_ff;
   logic [2:0]                           neg_q_ff;
   logic                                 zero_q_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = (2 * pdir_pkg::MAG_BITS)'(nm_ff[i]) * (2 * pdir_pkg::MAG_BITS)'(nm_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[pdir_pkg::ST_SQR]) begin
         sq_ff     <= sq_in;
         nm_q_ff   <= nm_ff;
         neg_q_ff  <= neg_s_ff;
         zero_q_ff <= zero_s_ff;
      end
   end

   // Stage ACC: sum of squares, seed of the root
   pdir_pkg::sqrt_stage_type acc_ff, acc_in;

   always_comb begin
      acc_in.src   = pdir_pkg::SUM_BITS'(sq_ff[0]) + pdir_pkg::SUM_BITS'(sq_ff[1])
                   + pdir_pkg::SUM_BITS'(sq_ff[2]);
      acc_in.rem   = '0;
      acc_in.root  = '0;
      acc_in.mag   = nm_q_ff;
      acc_in.neg   = neg_q_ff;
      acc_in.degen = zero_q_ff;
   end

   always_ff @(posedge clock) begin
      if (en[pdir_pkg::ST_ACC]) begin
         acc_ff <= acc_in;
      end
   end

   // Square root: one root bit per stage
   pdir_pkg::sqrt_stage_type rt_ff [pdir_pkg::ROOT_BITS];
   pdir_pkg::sqrt_stage_type rt_in [pdir_pkg::ROOT_BITS];

   for (genvar j = 0; j < pdir_pkg::ROOT_BITS; j++) begin : g_root
      pdir_pkg::sqrt_stage_type prev;
      logic [pdir_pkg::REM_BITS+1:0] cand, trial;

      always_comb begin
         prev  = (j == 0) ? acc_ff : rt_ff[(j == 0) ? 0 : j - 1];
         cand  = {prev.rem, prev.src[pdir_pkg::SUM_BITS-1 -: 2]};
         trial = {2'b00, prev.root, 2'b01};
         rt_in[j]     = prev;
         rt_in[j].src = {prev.src[pdir_pkg::SUM_BITS-3:0], 2'b00};
         if (cand >= trial) begin
            rt_in[j].rem  = pdir_pkg::REM_BITS'(cand - trial);
            rt_in[j].root = {prev.root[pdir_pkg::ROOT_BITS-2:0], 1'b1};
         end else begin
            rt_in[j].rem  = cand[pdir_pkg::REM_BITS-1:0];
            rt_in[j].root = {prev.root[pdir_pkg::ROOT_BITS-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (en[pdir_pkg::ST_RT0 + j]) begin
            rt_ff[j] <= rt_in[j];
         end
      end
   end

   // Stage NUM: numerators m*2^14 + len/2
   pdir_pkg::div_stage_type num_ff, num_in;

   always_comb begin
      num_in.len   = rt_ff[pdir_pkg::ROOT_BITS-1].root;
      num_in.neg   = rt_ff[pdir_pkg::ROOT_BITS-1].neg;
      num_in.degen = rt_ff[pdir_pkg::ROOT_BITS-1].degen;
      num_in.quo   = '0;
      for (int i = 0; i < 3; i++) begin
         num_in.rem[i] = {1'b0, rt_ff[pdir_pkg::ROOT_BITS-1].mag[i],
                          pdir_pkg::FRAC_BITS'(0)}
                       + pdir_pkg::NUM_BITS'(num_in.len >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (en[pdir_pkg::ST_NUM]) begin
         num_ff <= num_in;
      end
   end

   // Divider: one quotient bit per stage, three lanes
   pdir_pkg::div_stage_type dv_ff [pdir_pkg::Q_BITS];
   pdir_pkg::div_stage_type dv_in [pdir_pkg::Q_BITS];

   for (genvar j = 0; j < pdir_pkg::Q_BITS; j++) begin : g_div
      localparam int BP = pdir_pkg::Q_BITS - 1 - j;
      pdir_pkg::div_stage_type prev;
      logic [pdir_pkg::NUM_BITS-1:0] sub;

      always_comb begin
         prev     = (j == 0) ? num_ff : dv_ff[(j == 0) ? 0 : j - 1];
         sub      = pdir_pkg::NUM_BITS'(prev.len) << BP;
         dv_in[j] = prev;
         for (int i = 0; i < 3; i++) begin
            if (prev.rem[i] >= sub) begin
               dv_in[j].rem[i]     = prev.rem[i] - sub;
               dv_in[j].quo[i][BP] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en[pdir_pkg::ST_DV0 + j]) begin
            dv_ff[j] <= dv_in[j];
         end
      end
   end

   // Stage OUT: clamp, sign, degenerate; hold while rsp stalls
   logic [2:0][pdir_pkg::DIR_BITS-1:0] dir_ff, dir_in;
   logic                               degen_ff;
   logic [pdir_pkg::Q_BITS-1:0]        q;

   always_comb begin
      q = '0;
      for (int i = 0; i < 3; i++) begin
         q = dv_ff[pdir_pkg::Q_BITS-1].quo[i];
         if (q > pdir_pkg::ONE_Q14) begin
            q = pdir_pkg::ONE_Q14;
         end
         if (dv_ff[pdir_pkg::Q_BITS-1].degen) begin
            dir_in[i] = '0;
         end else if (dv_ff[pdir_pkg::Q_BITS-1].neg[i]) begin
            dir_in[i] = -pdir_pkg::DIR_BITS'(q);
         end else begin
            dir_in[i] = pdir_pkg::DIR_BITS'(q);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[pdir_pkg::ST_OUT]) begin
         dir_ff   <= dir_in;
         degen_ff <= dv_ff[pdir_pkg::Q_BITS-1].degen;
      end
   end

   assign rsp_tdata = {dir_ff[2], dir_ff[1], dir_ff[0]};
   assign rsp_tuser = degen_ff;

endmodule

/* design/pdir_check.sv */
`timescale 1ns / 1ps

module pdir_check (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [23:0]                         req_tdata,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [47:0]                         rsp_tdata,
   input logic                                rsp_tuser,
   input logic                                csr_psel,
   input logic                                csr_penable,
   input logic                                csr_pwrite,
   input logic [pdir_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input logic [pdir_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   input logic [pdir_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   input logic                                csr_pready
);

   localparam logic signed [15:0] POS_ONE = 16'sd16384;
   localparam logic signed [15:0] NEG_ONE = -16'sd16384;

   // A stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp word changed under stall");

   // Degenerate word carries a zero direction
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 48'd0)
      else $error("degenerate word with non-zero direction");

   // Components lie within plus and minus one
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         $signed(rsp_tdata[15:0])  <= POS_ONE && $signed(rsp_tdata[15:0])  >= NEG_ONE &&
         $signed(rsp_tdata[31:16]) <= POS_ONE && $signed(rsp_tdata[31:16]) >= NEG_ONE &&
         $signed(rsp_tdata[47:32]) <= POS_ONE && $signed(rsp_tdata[47:32]) >= NEG_ONE)
      else $error("direction component out of range");

   // Nothing comes out straight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

endmodule

bind primary_ray_direction pdir_check u_pdir_check (.*);

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

   localparam int LIMIT_CYCLES = 400000;
   localparam int RANDOM_WORDS = 830;

   typedef struct packed {
      logic [15:0] dx;
      logic [15:0] dy;
      logic [15:0] dz;
      logic        degen;
   } ray_dir_type;

   typedef struct {
      logic [11:0] row;
      logic [11:0] col;
      logic        known;
      ray_dir_type dir;
   } pixel_entry_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [23:0] req_tdata = '0;   // pixel_row [11:0], pixel_col [23:12]
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;        // dir_x [15:0], dir_y [31:16], dir_z [47:32]
   logic rsp_tuser;               // degenerate
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [pdir_pkg::CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [pdir_pkg::CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [pdir_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic csr_pready;

   // camera register shadow
   logic [59:0] cam_vec [4];
   logic [12:0] scr_w, scr_h;

   ray_dir_type pending_dirs [$];
   int errors = 0;
   int n_words = 0;
   int n_rays = 0;
   int n_degen = 0;
   int cycles = 0;
   bit rsp_random = 1'b1;

   primary_ray_direction dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycles);
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic longint signed comp_of(logic [59:0] v, int idx);
      logic [19:0] raw;
      raw = v[idx*20 +: 20];
      return longint'(signed'(raw));
   endfunction

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // work out the unit direction through one pixel
   function automatic ray_dir_type trace_dir(logic [11:0] row, logic [11:0] col);
      longint signed w, h, n;
      longint unsigned mag [3];
      bit neg [3];
      longint unsigned mx, sum, len, q;
      logic [15:0] comp [3];
      ray_dir_type r;
      w = (scr_w == 0) ? 1 : longint'(scr_w);
      h = (scr_h == 0) ? 1 : longint'(scr_h);
      mx = 0;
      for (int i = 0; i < 3; i++) begin
         n = (comp_of(cam_vec[pdir_pkg::REG_CORNER], i) - comp_of(cam_vec[pdir_pkg::REG_EYE], i))
             * (h * w)
           + longint'(row) * w * comp_of(cam_vec[pdir_pkg::REG_VERTICAL], i)
           + longint'(col) * h * comp_of(cam_vec[pdir_pkg::REG_HORIZ], i);
         neg[i] = n < 0;
         mag[i] = neg[i] ? longint'(-n) : longint'(n);
         if (mag[i] > mx) mx = mag[i];
      end
      r = '0;
      if (mx == 0) begin
         r.degen = 1'b1;
         return r;
      end
      while (mx >= (64'd1 << 31)) begin
         mx >>= 1;
         for (int i = 0; i < 3; i++) mag[i] >>= 1;
      end
      while (mx < (64'd1 << 30)) begin
         mx <<= 1;
         for (int i = 0; i < 3; i++) mag[i] <<= 1;
      end
      sum = 0;
      for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
      len = root_floor(sum);
      if (len == 0) len = 1;
      for (int i = 0; i < 3; i++) begin
         q = (mag[i] * 16384 + (len >> 1)) / len;
         if (q > 16384) q = 16384;
         if (neg[i]) q = -q;
         comp[i] = q[15:0];
      end
      r.dx = comp[0];
      r.dy = comp[1];
      r.dz = comp[2];
      return r;
   endfunction

   task automatic csr_write(pdir_pkg::reg_index_type idx, logic [59:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= pdir_pkg::CSR_ADDR_BITS'(idx) << 3;
      csr_pwdata <= pdir_pkg::CSR_DATA_BITS'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx <= pdir_pkg::REG_EYE) cam_vec[idx] = value;
      else if (idx == pdir_pkg::REG_WIDTH) scr_w = value[12:0];
      else scr_h = value[12:0];
   endtask

   function automatic logic [59:0] pack_vec(int x, int y, int z);
      return {20'(z), 20'(y), 20'(x)};
   endfunction

   function automatic logic [59:0] rand_vec(bit narrow);
      logic [59:0] v;
      v = 60'({$urandom, $urandom});
      if (narrow)
         v = pack_vec($urandom_range(0, 16383) - 8192, $urandom_range(0, 16383) - 8192,
                      $urandom_range(0, 16383) - 8192);
      return v;
   endfunction

   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic send_pixel(logic [11:0] row, logic [11:0] col, bit known,
                             ray_dir_type dir, bit with_gaps);
      int g;
      ray_dir_type e;
      g = with_gaps ? gap_len() : 0;
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      e = trace_dir(row, col);
      if (known && e !== dir) begin
         $display("%0t directed row disagrees with predictor: expected %h, predictor %h",
                  $time, dir, e);
         errors++;
      end
      req_tvalid <= 1'b1;
      req_tdata <= {col, row};
      do @(posedge clock); while (!req_tready);
      pending_dirs.push_back(known ? dir : e);
      n_words++;
   endtask

   // wait until every expected word has come back, then let the pipe settle
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_dirs.size() != 0) @(posedge clock);
      repeat (70) @(posedge clock);
   endtask

   // result side: random stalls while rsp_random is set, compare with the oldest prediction
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            ray_dir_type got, exp;
            got = {rsp_tdata[15:0], rsp_tdata[31:16], rsp_tdata[47:32], rsp_tuser};
            if (pending_dirs.size() == 0) begin
               $display("%0t unexpected word %h", $time, got);
               errors++;
            end else begin
               exp = pending_dirs.pop_front();
               if (got.dx !== exp.dx || got.dy !== exp.dy || got.dz !== exp.dz
                   || got.degen !== exp.degen) begin
                  $display("%0t mismatch: expected x %h y %h z %h degen %b,",
                           $time, exp.dx, exp.dy, exp.dz, exp.degen,
                           " got x %h y %h z %h degen %b",
                           got.dx, got.dy, got.dz, got.degen);
                  errors++;
               end
               n_rays++;
               if (exp.degen) n_degen++;
            end
         end
         rsp_tready <= rsp_random ? ($urandom_range(0, 99) < 70) : 1'b1;
      end
   end

   pixel_entry_type pixel_table [$];

   initial begin
      ray_dir_type zero_dir, degen_dir;
      ray_dir_type axis_dir;
      logic [11:0] r, c;

      zero_dir = '0;
      degen_dir = '0;
      degen_dir.degen = 1'b1;
      cam_vec[0] = '0; cam_vec[1] = '0; cam_vec[2] = '0; cam_vec[3] = '0;
      scr_w = 13'd640;
      scr_h = 13'd480;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // after reset every vector is zero, so any pixel is degenerate
      pixel_table.push_back('{12'd0, 12'd0, 1'b1, degen_dir});
      pixel_table.push_back('{12'hFFF, 12'hFFF, 1'b1, degen_dir});
      foreach (pixel_table[i])
         send_pixel(pixel_table[i].row, pixel_table[i].col, 1'b1, pixel_table[i].dir, 1'b0);
      drain();

      // straight down +z: corner ahead of the eye, no edges at pixel 0,0
      csr_write(pdir_pkg::REG_CORNER, pack_vec(0, 0, 4096));
      csr_write(pdir_pkg::REG_VERTICAL, pack_vec(0, -8192, 0));
      csr_write(pdir_pkg::REG_HORIZ, pack_vec(8192, 0, 0));
      csr_write(pdir_pkg::REG_EYE, pack_vec(0, 0, 0));
      csr_write(pdir_pkg::REG_WIDTH, 60'd4096);
      csr_write(pdir_pkg::REG_HEIGHT, 60'd4096);
      pixel_table.delete();
      axis_dir = '0;
      axis_dir.dz = 16'd16384;
      pixel_table.push_back('{12'd0, 12'd0, 1'b1, axis_dir});
      pixel_table.push_back('{12'hFFF, 12'd0, 1'b0, zero_dir});
      pixel_table.push_back('{12'd0, 12'hFFF, 1'b0, zero_dir});
      pixel_table.push_back('{12'hFFF, 12'hFFF, 1'b0, zero_dir});
      pixel_table.push_back('{12'd2048, 12'd2048, 1'b0, zero_dir});
      pixel_table.push_back('{12'hAAA, 12'h555, 1'b0, zero_dir});
      pixel_table.push_back('{12'h555, 12'hAAA, 1'b0, zero_dir});
      foreach (pixel_table[i])
         send_pixel(pixel_table[i].row, pixel_table[i].col, pixel_table[i].known,
                    pixel_table[i].dir, 1'b1);
      drain();

      // extreme components, zero screen sizes, rows beyond the screen
      csr_write(pdir_pkg::REG_CORNER, pack_vec(-524288, 524287, -524288));
      csr_write(pdir_pkg::REG_VERTICAL, pack_vec(524287, -524288, 524287));
      csr_write(pdir_pkg::REG_HORIZ, pack_vec(-524288, -524288, 524287));
      csr_write(pdir_pkg::REG_EYE, pack_vec(524287, -524288, 524287));
      csr_write(pdir_pkg::REG_WIDTH, 60'd0);
      csr_write(pdir_pkg::REG_HEIGHT, 60'd0);
      pixel_table.delete();
      axis_dir = '0;
      axis_dir.dx = 16'hC000;
      pixel_table.push_back('{12'd0, 12'd0, 1'b0, zero_dir});
      pixel_table.push_back('{12'hFFF, 12'hFFF, 1'b0, zero_dir});
      pixel_table.push_back('{12'd1, 12'd0, 1'b0, zero_dir});
      pixel_table.push_back('{12'd0, 12'd1, 1'b0, zero_dir});
      foreach (pixel_table[i])
         send_pixel(pixel_table[i].row, pixel_table[i].col, 1'b0, zero_dir, 1'b1);
      drain();

      // pixel point on the eye: corner equal to eye at pixel 0,0
      csr_write(pdir_pkg::REG_EYE, pack_vec(-524288, 524287, -524288));
      csr_write(pdir_pkg::REG_WIDTH, 60'd1);
      csr_write(pdir_pkg::REG_HEIGHT, 60'd8191);
      send_pixel(12'd0, 12'd0, 1'b1, degen_dir, 1'b0);
      send_pixel(12'd7, 12'd3, 1'b0, zero_dir, 1'b0);
      drain();

      // random phases with fresh camera settings
      for (int ph = 0; ph < 10; ph++) begin
         csr_write(pdir_pkg::REG_CORNER, rand_vec(ph % 3 != 0));
         csr_write(pdir_pkg::REG_VERTICAL, rand_vec(ph % 3 != 0));
         csr_write(pdir_pkg::REG_HORIZ, rand_vec(ph % 3 != 0));
         csr_write(pdir_pkg::REG_EYE, rand_vec(ph % 3 != 0));
         csr_write(pdir_pkg::REG_WIDTH,
                   (ph == 4) ? 60'd4096 : 60'($urandom_range(0, 8191)));
         csr_write(pdir_pkg::REG_HEIGHT,
                   (ph == 5) ? 60'd1 : 60'($urandom_range(0, 8191)));
         rsp_random = (ph != 2);
         for (int k = 0; k < RANDOM_WORDS / 10; k++) begin
            r = 12'($urandom);
            c = 12'($urandom);
            // now and then aim at the eye to hit the degenerate case
            if ($urandom_range(0, 49) == 0) begin
               drain();
               csr_write(pdir_pkg::REG_EYE, cam_vec[pdir_pkg::REG_CORNER]);
               r = 0;
               c = 0;
            end
            send_pixel(r, c, 1'b0, zero_dir, ph != 2);
         end
         drain();
      end

      $display("covered %0d pixels, %0d directions checked, %0d degenerate,",
               n_words, n_rays, n_degen);
      $display("over reset values, axis and extreme cameras and random settings");
      if (errors == 0 && pending_dirs.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
